// ===== src/transition_torque_current_calc_defines.svh =====
// Assertion macros shared by the transition torque current block.
`ifndef TRANSITION_TORQUE_CURRENT_CALC_DEFINES_SVH
`define TRANSITION_TORQUE_CURRENT_CALC_DEFINES_SVH
// Implication check, reset qualified.
`define TTCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication check, reset qualified.
`define TTCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/ttcc_pkg.sv =====
// Shared constants and types of the transition torque current block.
`default_nettype none
package ttcc_pkg;
  localparam int unsigned NumDivStages = 22;
  localparam logic [31:0] MinParam = 32'd17;
  localparam logic [16:0] Sqrt3Q16 = 17'd113511;
  localparam logic [16:0] Recip10Q19 = 17'd52429;
  localparam logic [14:0] MinLimit = 15'd25;
  localparam logic [1:0] RegInertia = 2'd0;
  localparam logic [1:0] RegPolePairs = 2'd1;
  localparam logic [1:0] RegFlux = 2'd2;
  localparam logic [1:0] RegRated = 2'd3;

  // Side data carried alongside the division.
  typedef struct packed {
    logic        neg;
    logic [12:0] bias;
    logic [14:0] lim;
  } side_t;

  // One row of the restoring divider.
  typedef struct packed {
    logic [127:0] num;
    logic [105:0] den;
    logic [21:0]  q;
    side_t        side;
  } div_row_t;
endpackage
`default_nettype wire

// ===== src/ttcc_front.sv =====
// Front stages: magnitudes, floors, products forming numerator and divisor.
`default_nettype none
module ttcc_front (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                stall,
  input  wire logic                in_valid,
  input  wire logic [15:0]         phase_error,
  input  wire logic [31:0]         switch_time,
  input  wire logic [15:0]         open_loop_id,
  input  wire logic [31:0]         rotor_inertia,
  input  wire logic [6:0]          pole_pairs,
  input  wire logic [23:0]         flux_linkage,
  input  wire logic [15:0]         rated_current_rms,
  output logic                     out_valid,
  output ttcc_pkg::div_row_t       row
);
  // stage 1
  logic        v1;
  logic [31:0] t1;
  logic [32:0] k1;
  logic [47:0] jp1;
  ttcc_pkg::side_t s1;
  // stage 2
  logic        v2;
  logic [63:0] tt2;
  logic [32:0] k2;
  logic [47:0] jp2;
  ttcc_pkg::side_t s2;
  // stage 3
  logic        v3;
  logic [64:0] pl3, ph3;
  logic [47:0] jp3;
  ttcc_pkg::side_t s3;

  logic [15:0] pe_mag, id_mag;
  logic [32:0] id_div;
  logic [6:0]  pp;
  logic [23:0] psi;
  logic [31:0] t_fl;
  logic [32:0] lim_raw;
  logic [15:0] lim_c;
  logic [96:0] den_full;
  logic [76:0] den_sat;

  assign pe_mag  = phase_error[15] ? 16'(-phase_error) : phase_error;
  assign id_mag  = open_loop_id[15] ? 16'(-open_loop_id) : open_loop_id;
  // divide by ten through a reciprocal, exact over the whole magnitude range
  assign id_div  = 33'(id_mag) * 33'(ttcc_pkg::Recip10Q19);
  assign pp      = (pole_pairs == 7'd0) ? 7'd1 : pole_pairs;
  assign psi     = (flux_linkage < 24'(ttcc_pkg::MinParam)) ? 24'(ttcc_pkg::MinParam)
                                                            : flux_linkage;
  assign t_fl    = (switch_time < ttcc_pkg::MinParam) ? ttcc_pkg::MinParam : switch_time;
  assign lim_raw = 33'((34'(rated_current_rms) * 34'(ttcc_pkg::Sqrt3Q16)) >> 16);
  assign lim_c   = (lim_raw < 33'(ttcc_pkg::MinLimit)) ? 16'(ttcc_pkg::MinLimit) :
                   (lim_raw > 33'd32767) ? 16'd32767 : lim_raw[15:0];
  assign den_full = {32'd0, pl3} + {ph3, 32'd0};
  // a divisor of 2^76 or more already exceeds any numerator, so hold it there
  assign den_sat  = (den_full[96:76] != 21'd0) ? {1'b1, 76'd0} : den_full[76:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (!stall) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      t1  <= t_fl;
      k1  <= 33'(33'd3 * 33'(pp) * 33'(psi));
      jp1 <= 48'(rotor_inertia) * 48'(pe_mag);
      s1.neg  <= phase_error[15];
      s1.bias <= id_div[31:19];
      s1.lim  <= lim_c[14:0];
      tt2 <= 64'(t1) * 64'(t1);
      k2  <= k1;
      jp2 <= jp1;
      s2  <= s1;
      pl3 <= 65'(tt2[31:0]) * 65'(k2);
      ph3 <= 65'(tt2[63:32]) * 65'(k2);
      jp3 <= jp2;
      s3  <= s2;
      row.num  <= {52'd0, jp3, 28'd0};
      row.den  <= {8'd0, den_sat, 21'd0};
      row.q    <= 22'd0;
      row.side <= s3;
    end
  end
endmodule
`default_nettype wire

// ===== src/ttcc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^21.
`default_nettype none
module ttcc_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          stall,
  input  wire logic          in_valid,
  input  ttcc_pkg::div_row_t in_row,
  output logic               out_valid,
  output ttcc_pkg::div_row_t out_row
);
  localparam int unsigned N = ttcc_pkg::NumDivStages;
  ttcc_pkg::div_row_t rows [N+1];
  logic [N:0] v;

  assign rows[0] = in_row;
  assign v[0] = in_valid;

  for (genvar i = 0; i < N; i++) begin : g_st
    ttcc_pkg::div_row_t nx;
    logic [105:0] d_sh;
    always_comb begin
      nx = rows[i];
      d_sh = rows[i].den >> i;
      if (i == 0) begin
        if (rows[i].num >= {22'd0, rows[i].den}) nx.q = 22'h200000;
      end else if (rows[i].q[21] == 1'b0 && rows[i].num >= {22'd0, d_sh}) begin
        nx.num = rows[i].num - {22'd0, d_sh};
        nx.q[N-1-i] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) v[i+1] <= 1'b0;
      else if (!stall) v[i+1] <= v[i];
    end
    always_ff @(posedge clk) begin
      if (!stall) rows[i+1] <= nx;
    end
  end

  assign out_valid = v[N];
  assign out_row = rows[N];
endmodule
`default_nettype wire

// ===== src/transition_torque_current_calc.sv =====
// Top level: register file, front products, divider pipeline and output stage.
// Usage: input words arrive on in_valid/in_stall with phase_error, switch_time
// and open_loop_id; results leave on out_valid/out_stall as iq_command.
// Registers are written over the APB port (inertia, pole pairs, flux, rated
// current at byte addresses 0, 4, 8, 12); the user writes them only while
// the block is idle, which the block itself does not enforce.
// An accepted word reaches out_valid through 28 register stages: four product
// stages, 22 divider stages of one quotient bit each, two sign/limit stages.
// Throughput is one word per cycle while out_stall stays low.
// Reset clears all valid bits and loads the register reset values.
// When the receiver stalls a valid output word, the whole pipeline holds; in_stall
// follows out_stall whenever the output holds a word, so nothing is lost or repeated.
`default_nettype none
`include "transition_torque_current_calc_defines.svh"
module transition_torque_current_calc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] phase_error,
  input  wire logic [31:0] switch_time,
  input  wire logic [15:0] open_loop_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      iq_command,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] rotor_inertia;
  logic [6:0]  pole_pairs;
  logic [23:0] flux_linkage;
  logic [15:0] rated_current_rms;
  logic        stall;
  logic        f_valid, d_valid, s_valid;
  ttcc_pkg::div_row_t f_row, d_row;
  logic [22:0] mag;
  logic        s_neg;
  logic [14:0] s_lim;
  logic [15:0] sat;

  assign pready = 1'b1;
  assign stall = out_valid & out_stall;
  assign in_stall = stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotor_inertia <= 32'd0;
      pole_pairs <= 7'd4;
      flux_linkage <= 24'd0;
      rated_current_rms <= 16'd0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (paddr[3:2])
        ttcc_pkg::RegInertia:   rotor_inertia <= pwdata;
        ttcc_pkg::RegPolePairs: pole_pairs <= pwdata[6:0];
        ttcc_pkg::RegFlux:      flux_linkage <= pwdata[23:0];
        ttcc_pkg::RegRated:     rated_current_rms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ttcc_pkg::RegInertia:   prdata = rotor_inertia;
      ttcc_pkg::RegPolePairs: prdata = {25'd0, pole_pairs};
      ttcc_pkg::RegFlux:      prdata = {8'd0, flux_linkage};
      ttcc_pkg::RegRated:     prdata = {16'd0, rated_current_rms};
      default:                prdata = 32'd0;
    endcase
  end

  ttcc_front u_front (
    .clk(clk), .rst(rst), .stall(stall), .in_valid(in_valid),
    .phase_error(phase_error), .switch_time(switch_time), .open_loop_id(open_loop_id),
    .rotor_inertia(rotor_inertia), .pole_pairs(pole_pairs),
    .flux_linkage(flux_linkage), .rated_current_rms(rated_current_rms),
    .out_valid(f_valid), .row(f_row)
  );

  ttcc_div u_div (
    .clk(clk), .rst(rst), .stall(stall), .in_valid(f_valid), .in_row(f_row),
    .out_valid(d_valid), .out_row(d_row)
  );

  // add bias and register before the limit
  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (!stall) s_valid <= d_valid;
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      mag   <= 23'(d_row.q) + 23'(d_row.side.bias);
      s_neg <= d_row.side.neg;
      s_lim <= d_row.side.lim;
    end
  end

  assign sat = (mag > 23'(s_lim)) ? {1'b0, s_lim} : mag[15:0];

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (!stall) out_valid <= s_valid;
  end
  always_ff @(posedge clk) begin
    if (!stall) iq_command <= s_neg ? 16'(-sat) : sat;
  end

  `TTCC_ASSERT_NXT(a_hold_out, out_valid && out_stall, out_valid && $stable(iq_command),
    "result word changed under stall")
  `TTCC_ASSERT_IMP(a_stall_link, out_valid && out_stall, in_stall,
    "input taken while output held")
  `TTCC_ASSERT_IMP(a_lim_range, s_valid, s_lim >= ttcc_pkg::MinLimit,
    "limit below minimum")
endmodule
`default_nettype wire
